@@ src/fpn_pkg.sv @@
`default_nettype none

package fpn_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int MAG_W               = SAMPLE_W + 1;
  localparam int QUO_W               = SAMPLE_W - 1;
  localparam int DIV_STEPS           = QUO_W;
  localparam int FRAME_DEPTH_DEFAULT = 64;

  localparam logic [SAMPLE_W-1:0] Q_MAX_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] Q_MAX_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       frame_end;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] scaled_sample;
    logic                       final_out;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic div_load;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic last_sample;
  } ctrl_stat_t;

endpackage

`default_nettype wire

@@ src/fpn_ctrl.sv @@
`default_nettype none

module fpn_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               frame_end,
  input  wire fpn_pkg::ctrl_stat_t stat,
  output logic                    busy,
  output fpn_pkg::ctrl_cmd_t      cmd
);
  import fpn_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (frame_end) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = stat.last_sample ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ src/fpn_datapath.sv @@
`default_nettype none

module fpn_datapath #(
  parameter int FRAME_DEPTH = fpn_pkg::FRAME_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fpn_pkg::item_t     item,
  input  wire fpn_pkg::ctrl_cmd_t cmd,
  output fpn_pkg::ctrl_stat_t     stat,
  output fpn_pkg::result_t        result,
  output logic                    result_valid
);
  import fpn_pkg::*;

  localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int REM_W = MAG_W + 1;

  logic [SAMPLE_W-1:0] frame_store [FRAME_DEPTH];
  logic [CNT_W-1:0]    fill_count;
  logic [MAG_W-1:0]    peak;
  logic [IDX_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] rd_data;

  logic [REM_W-1:0]    rem;
  logic [QUO_W-1:0]    quo;
  logic                neg;
  logic                full_scale;
  logic                peak_zero;

  logic [MAG_W-1:0]    in_mag;
  logic [MAG_W-1:0]    rd_mag;
  logic [REM_W-1:0]    rem_shift;
  logic                rem_ge;
  logic                has_room;
  logic [SAMPLE_W-1:0] quo_ext;
  logic [SAMPLE_W-1:0] scaled;

  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] ext;
    ext = {s[SAMPLE_W-1], s};
    return s[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

  assign in_mag    = magnitude(item.sample_in);
  assign rd_mag    = magnitude(rd_data);
  assign has_room  = (fill_count < CNT_W'(FRAME_DEPTH));
  assign rem_shift = {rem[REM_W-2:0], 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, peak});
  assign quo_ext   = {1'b0, quo};

  assign stat.last_sample = ((CNT_W'(rd_idx) + CNT_W'(1)) == fill_count);

  always_comb begin
    if (peak_zero) begin
      scaled = '0;
    end else if (full_scale) begin
      scaled = neg ? Q_MAX_NEG : Q_MAX_POS;
    end else begin
      scaled = neg ? (~quo_ext + SAMPLE_W'(1)) : quo_ext;
    end
  end

  // Frame buffer: accepted samples written while not full; registered read.
  always_ff @(posedge clk) begin
    if (cmd.accept && has_room) begin
      frame_store[fill_count[IDX_W-1:0]] <= item.sample_in;
    end
    if (cmd.rd_en) begin
      rd_data <= frame_store[rd_idx];
    end
  end

  // Restoring divider: the magnitude is at most the peak (equal saturates),
  // so one trial subtract per quotient bit suffices.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem        <= {1'b0, rd_mag};
      quo        <= '0;
      neg        <= rd_data[SAMPLE_W-1];
      full_scale <= (rd_mag == peak);
      peak_zero  <= (peak == '0);
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (rem_shift - {1'b0, peak}) : rem_shift;
      quo <= {quo[QUO_W-2:0], rem_ge};
    end
    if (cmd.emit) begin
      result.scaled_sample <= scaled;
      result.final_out     <= stat.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      peak         <= '0;
      rd_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.accept) begin
        rd_idx <= '0;
        if (has_room) begin
          fill_count <= fill_count + CNT_W'(1);
          if (in_mag > peak) begin
            peak <= in_mag;
          end
        end
      end
      if (cmd.emit) begin
        rd_idx <= rd_idx + IDX_W'(1);
        if (stat.last_sample) begin
          fill_count <= '0;
          peak       <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/frame_peak_normalizer.sv @@
`default_nettype none

// Frame peak normalizer.
// Samples enter as transactions on start/busy: a transaction is taken at a
// rising edge where start is high and busy is low. Each sample is stored in
// the frame buffer (up to FRAME_DEPTH; extra samples are dropped) and the
// largest magnitude of the frame is tracked. A sample without frame_end leaves
// busy low.
// A sample with frame_end raises busy and starts playback: every stored sample
// is read back in order and divided by the peak, giving (sample << 15) / peak
// truncated toward zero, with +1.0 saturated to 32767 and an all-zero frame
// giving zeros. Each result passes through a buffer read, a divider load,
// fifteen shift-subtract steps of the restoring divider, and an emit.
// Each result is held on result, with result_valid high for one cycle;
// final_out marks the last one. The receiver cannot stall and must take it.
// busy drops as the last result is registered, so a new frame may start in
// the cycle that last result is presented.
// Reset clears the fill count, the peak and the controller; buffer contents
// are not cleared and are only read after being written.
module frame_peak_normalizer #(
  parameter int FRAME_DEPTH = fpn_pkg::FRAME_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire fpn_pkg::item_t   item,
  output fpn_pkg::result_t      result,
  output logic                  result_valid
);
  import fpn_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // The controller sequences read, divide and emit for each stored sample.
  fpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .frame_end (item.frame_end),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // The datapath holds the buffer, the peak tracker and the divider.
  fpn_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire
